// ===== hw/rtl/keypad_scan_debounce_entry_macros.svh =====
// Assertion macros used by the keypad scanner top level.
`ifndef KEYPAD_SCAN_DEBOUNCE_ENTRY_MACROS_SVH
`define KEYPAD_SCAN_DEBOUNCE_ENTRY_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define KSD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define KSD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/ksd_pkg.sv =====
// Shared types, constants and key code table for the keypad scanner.
package ksd_pkg;

	localparam int unsigned ColW     = 3;
	localparam int unsigned Rows     = 4;
	localparam int unsigned KeyW     = 4;
	localparam int unsigned CountW   = 16;
	localparam int unsigned CodeW    = 10;
	localparam int unsigned NumKeys  = 12;
	localparam int unsigned ProdW    = CountW + 4;

	localparam logic [KeyW-1:0]   KEY_STAR    = 4'd10;
	localparam logic [KeyW-1:0]   KEY_HASH    = 4'd11;
	localparam logic [KeyW-1:0]   KEY_UNKNOWN = 4'd12;
	localparam logic [CountW-1:0] COUNT_MAX   = 16'hFFFF;
	localparam logic [CountW-1:0] DEFAULT_NOTE_COUNT_RST = 16'd300;

	// Row/column codes in key order: digits 0 to 9, then star and hash.
	localparam logic [CodeW-1:0] KEY_CODES [NumKeys] = '{
		10'h108, 10'h081, 10'h101, 10'h201, 10'h082, 10'h102,
		10'h202, 10'h084, 10'h104, 10'h204, 10'h088, 10'h208
	};

	typedef enum logic [3:0] {
		DB_NO_PUSH       = 4'b0001,
		DB_MAYBE_PUSHED  = 4'b0010,
		DB_PUSHED        = 4'b0100,
		DB_MAYBE_NO_PUSH = 4'b1000
	} db_state_t;

	typedef struct packed {
		logic            press;
		logic [KeyW-1:0] key;
	} key_info_t;

	typedef struct packed {
		logic              accepted;
		logic [KeyW-1:0]   key_code;
		logic              done;
		logic [KeyW-1:0]   song;
		logic [CountW-1:0] count;
	} entry_res_t;

endpackage

// ===== hw/rtl/keypad_scan_debounce_entry.sv =====
// Top level of the keypad scanner: input stage, entry logic and result register.
//
//  Channel  Handshake             Payload
//  input    in_valid / in_ready   row0_cols..row3_cols, busy_req
//  output   out_valid / out_ready key_present, key_accepted, key_code,
//                                 entry_done, chosen_song, note_count
//  config   cfg_wr_en             cfg_wr_data (default note count)
//
// One item per cycle sustained while the output is taken; an item enters the input register
// when accepted and moves into the result register through decode, debounce and entry logic.
// The entry state updates as an item moves into the result register, so the next item
// sees it at once. Reset clears the debouncer, the entry state and the default count
// (to 300). A stalled output holds both stages; the input stage refills as soon as
// the result register empties or is taken.
`include "keypad_scan_debounce_entry_macros.svh"

module keypad_scan_debounce_entry import ksd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [ColW-1:0]   row0_cols,
	input  logic [ColW-1:0]   row1_cols,
	input  logic [ColW-1:0]   row2_cols,
	input  logic [ColW-1:0]   row3_cols,
	input  logic              busy_req,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              key_present,
	output logic              key_accepted,
	output logic [KeyW-1:0]   key_code,
	output logic              entry_done,
	output logic [KeyW-1:0]   chosen_song,
	output logic [CountW-1:0] note_count,
	input  logic              cfg_wr_en,
	input  logic [CountW-1:0] cfg_wr_data
);

	logic              valid_s1;
	logic [ColW-1:0]   row0_s1, row1_s1, row2_s1, row3_s1;
	logic              busy_s1;
	logic              out_valid_q;
	logic              present_q;
	entry_res_t        res_q;
	logic [CountW-1:0] default_note_count_q;
	logic              advance;
	key_info_t         info;
	entry_res_t        res;

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_note_count_q <= DEFAULT_NOTE_COUNT_RST;
		end else if (cfg_wr_en) begin
			default_note_count_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			row0_s1 <= row0_cols;
			row1_s1 <= row1_cols;
			row2_s1 <= row2_cols;
			row3_s1 <= row3_cols;
			busy_s1 <= busy_req;
		end
	end

	ksd_key_match u_match (
		.row0_cols (row0_s1),
		.row1_cols (row1_s1),
		.row2_cols (row2_s1),
		.row3_cols (row3_s1),
		.info      (info)
	);

	ksd_entry u_entry (
		.clk                (clk),
		.arst_n             (arst_n),
		.step               (valid_s1 && advance),
		.busy               (busy_s1),
		.info               (info),
		.default_note_count (default_note_count_q),
		.res                (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			present_q <= info.press;
			res_q     <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign key_present  = present_q;
	assign key_accepted = res_q.accepted;
	assign key_code     = res_q.key_code;
	assign entry_done   = res_q.done;
	assign chosen_song  = res_q.song;
	assign note_count   = res_q.count;

	`KSD_ASSERT_NOW(a_accept_needs_press, out_valid_q && res_q.accepted, present_q,
		"key accepted without a press")
	`KSD_ASSERT_NOW(a_done_needs_accept, out_valid_q && res_q.done, res_q.accepted,
		"entry committed without an accepted key")
	`KSD_ASSERT_NOW(a_done_count_nonzero, out_valid_q && res_q.done,
		(res_q.count != '0) || (default_note_count_q == '0), "zero count committed")
	`KSD_ASSERT_NEXT(a_busy_blocks_accept, valid_s1 && advance && busy_s1,
		!res_q.accepted && !res_q.done, "accepted key while busy")

endmodule

// ===== hw/rtl/ksd_key_match.sv =====
// Row priority encoder and key code lookup for one scan tick.
module ksd_key_match import ksd_pkg::*; (
	input  logic [ColW-1:0] row0_cols,
	input  logic [ColW-1:0] row1_cols,
	input  logic [ColW-1:0] row2_cols,
	input  logic [ColW-1:0] row3_cols,
	output key_info_t       info
);

	logic [CodeW-1:0] code;
	logic [KeyW-1:0]  key;

	// The first row with any column high wins; columns sit above the row bit.
	always_comb begin
		code = '0;
		if (row0_cols != '0) begin
			code = {row0_cols, 3'b000, 4'b0001};
		end else if (row1_cols != '0) begin
			code = {row1_cols, 3'b000, 4'b0010};
		end else if (row2_cols != '0) begin
			code = {row2_cols, 3'b000, 4'b0100};
		end else if (row3_cols != '0) begin
			code = {row3_cols, 3'b000, 4'b1000};
		end
	end

	always_comb begin
		key = KEY_UNKNOWN;
		for (int i = NumKeys - 1; i >= 0; i--) begin
			if (KEY_CODES[i] == code) begin
				key = KeyW'(i);
			end
		end
	end

	assign info.press = (code != '0);
	assign info.key   = (code != '0) ? key : '0;

endmodule

// ===== hw/rtl/ksd_entry.sv =====
// Debounce state machine and song/count entry sequencing.
module ksd_entry import ksd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              busy,
	input  key_info_t         info,
	input  logic [CountW-1:0] default_note_count,
	output entry_res_t        res
);

	db_state_t         db_q, db_nxt;
	logic              song_chosen_q;
	logic [KeyW-1:0]   pending_song_q;
	logic [CountW-1:0] entry_value_q;
	logic              accept;
	logic [ProdW-1:0]  next_value;
	logic [CountW-1:0] sat_value;
	logic              commit;

	always_comb begin
		db_nxt = db_q;
		accept = 1'b0;
		case (db_q)
			DB_NO_PUSH: begin
				db_nxt = info.press ? DB_MAYBE_PUSHED : DB_NO_PUSH;
			end
			DB_MAYBE_PUSHED: begin
				db_nxt = info.press ? DB_PUSHED : DB_NO_PUSH;
				accept = info.press;
			end
			DB_PUSHED: begin
				db_nxt = info.press ? DB_PUSHED : DB_MAYBE_NO_PUSH;
			end
			DB_MAYBE_NO_PUSH: begin
				db_nxt = info.press ? DB_PUSHED : DB_NO_PUSH;
			end
			default: begin
				db_nxt = DB_NO_PUSH;
			end
		endcase
		if (busy) begin
			db_nxt = db_q;
			accept = 1'b0;
		end
	end

	assign next_value = ProdW'(entry_value_q) * ProdW'(10) + ProdW'(info.key);
	assign sat_value  = (next_value > ProdW'(COUNT_MAX)) ? COUNT_MAX : next_value[CountW-1:0];
	assign commit     = accept && song_chosen_q && (info.key >= KEY_HASH);

	assign res.accepted = accept;
	assign res.key_code = accept ? info.key : '0;
	assign res.done     = commit;
	assign res.song     = commit ? pending_song_q : '0;
	assign res.count    = !commit ? '0 :
		(entry_value_q != '0) ? entry_value_q : default_note_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			db_q           <= DB_NO_PUSH;
			song_chosen_q  <= 1'b0;
			pending_song_q <= '0;
			entry_value_q  <= '0;
		end else if (step) begin
			db_q <= db_nxt;
			if (accept) begin
				if (!song_chosen_q) begin
					pending_song_q <= info.key;
					song_chosen_q  <= 1'b1;
				end else if (info.key < KEY_HASH) begin
					entry_value_q <= sat_value;
				end else begin
					song_chosen_q  <= 1'b0;
					pending_song_q <= '0;
					entry_value_q  <= '0;
				end
			end
		end
	end

endmodule
